FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked on every rising clock edge outside reset.
`define NPCA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("npca assertion failed");
// Condition implies a consequence on the next clock edge.
`define NPCA_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("npca assertion failed");
`else
`define NPCA_ASSERT(lbl, prop)
`define NPCA_ASSERT_NEXT(lbl, cond, cons)
`endif
`endif

FILE: rtl/core/npca_pkg.sv
// Types and constants of the node pool chain allocator.
package npca_pkg;

	localparam logic [1:0] OP_GET  = 2'd0;
	localparam logic [1:0] OP_HIER = 2'd1;
	localparam logic [1:0] OP_FREE = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_STRAY   = 2'd2;

	localparam logic [7:0] NO_PARENT = 8'hFF;

	typedef struct packed {
		logic [1:0] opcode;
		logic [9:0] node_count;
		logic [7:0] parent_offset;
		logic [8:0] chain_head;
		logic       chain_present;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] node_index;
		logic [8:0] parent_index;
		logic       parent_valid;
		logic       chain_done;
		logic [9:0] free_remaining;
	} out_item_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_PWALK,
		S_PWALK_WT,
		S_NEXT_RD,
		S_NEXT_WT,
		S_FWALK,
		S_FWALK_WT,
		S_FDONE,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic init_wr;
		logic ld_item;
		logic do_get;
		logic res_plain;
		logic res_stray;
		logic do_short;
		logic pwalk_start;
		logic walk_rd;
		logic pwalk_step;
		logic next_rd;
		logic commit;
		logic fwalk_start;
		logic fwalk_step;
		logic free_done;
		logic out_ld;
	} ctl_cmd_t;

	typedef struct packed {
		logic       init_last;
		logic [1:0] op;
		logic       pending_zero;
		logic       cursor_nil;
		logic       free_ok;
		logic       walk_nil;
		logic       steps_zero;
		logic       link_nil;
		logic       cnt_full;
	} dp_sts_t;

endpackage

FILE: rtl/core/npca_datapath.sv
// Datapath: link memory, free list registers, walk unit and result registers.
module npca_datapath #(
	parameter int POOL_SIZE = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  npca_pkg::in_item_t  in_item,
	input  npca_pkg::ctl_cmd_t  cmd,
	output npca_pkg::dp_sts_t   sts,
	output npca_pkg::out_item_t out_item
);
	localparam int LW = $clog2(POOL_SIZE + 1);
	localparam int AW = $clog2(POOL_SIZE);
	localparam int NW = (LW > 10) ? LW : 10;
	localparam logic [LW-1:0] NIL = LW'(POOL_SIZE);

	logic [LW-1:0] mem [POOL_SIZE];
	logic [LW-1:0] rdata_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [LW-1:0] mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	npca_pkg::in_item_t  item_q;
	npca_pkg::out_item_t res_q;
	npca_pkg::out_item_t res_nx;
	npca_pkg::out_item_t out_q;
	logic [AW-1:0] init_q;
	logic [LW-1:0] free_head_q;
	logic [LW-1:0] free_count_q;
	logic [LW-1:0] pending_q;
	logic [LW-1:0] chain_top_q;
	logic [LW-1:0] cursor_q;
	logic [LW-1:0] walk_q;
	logic [7:0]    steps_q;
	logic [LW-1:0] cnt_q;

	logic [NW-1:0] n_ext;
	logic [NW-1:0] head_ext;
	logic [LW-1:0] link_nx;
	logic          get_ok;
	logic          par_ok;
	logic [LW:0]   sum_w;
	logic [LW-1:0] fc_add;
	logic [LW-1:0] fc_sub;

	assign n_ext    = NW'(item_q.node_count);
	assign head_ext = NW'(item_q.chain_head);
	assign link_nx  = (rdata_q < NIL) ? rdata_q : NIL;
	assign get_ok   = (n_ext != '0) && (n_ext <= NW'(free_count_q)) && (pending_q == '0);
	assign par_ok   = walk_q < NIL;
	assign sum_w    = {1'b0, free_count_q} + {1'b0, cnt_q};
	assign fc_add   = (sum_w > (LW+1)'(POOL_SIZE)) ? NIL : sum_w[LW-1:0];
	assign fc_sub   = free_count_q - LW'(n_ext);

	assign sts.init_last    = init_q == AW'(POOL_SIZE - 1);
	assign sts.op           = item_q.opcode;
	assign sts.pending_zero = pending_q == '0;
	assign sts.cursor_nil   = cursor_q >= NIL;
	assign sts.free_ok      = item_q.chain_present && (head_ext < NW'(POOL_SIZE))
		&& (pending_q == '0);
	assign sts.walk_nil     = walk_q >= NIL;
	assign sts.steps_zero   = steps_q == '0;
	assign sts.link_nil     = link_nx == NIL;
	assign sts.cnt_full     = cnt_q == NIL;

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = init_q;
		mem_wd = LW'(init_q) + LW'(1);
		if (cmd.commit && pending_q == LW'(1)) begin
			mem_we = 1'b1;
			mem_wa = cursor_q[AW-1:0];
			mem_wd = NIL;
		end else if (cmd.free_done) begin
			mem_we = 1'b1;
			mem_wa = walk_q[AW-1:0];
			mem_wd = free_head_q;
		end else if (cmd.init_wr) begin
			mem_we = 1'b1;
		end
	end

	assign mem_re = cmd.walk_rd || cmd.next_rd;
	assign mem_ra = cmd.next_rd ? cursor_q[AW-1:0] : walk_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q       <= '0;
			free_head_q  <= '0;
			free_count_q <= NIL;
			pending_q    <= '0;
			chain_top_q  <= '0;
			cursor_q     <= '0;
		end else begin
			if (cmd.init_wr) begin
				init_q <= init_q + AW'(1);
			end
			if (cmd.do_get && get_ok) begin
				free_count_q <= fc_sub;
				chain_top_q  <= free_head_q;
				cursor_q     <= free_head_q;
				pending_q    <= LW'(n_ext);
			end
			if (cmd.do_short) begin
				pending_q   <= '0;
				free_head_q <= NIL;
			end
			if (cmd.commit) begin
				cursor_q  <= link_nx;
				pending_q <= pending_q - LW'(1);
				if (pending_q == LW'(1)) begin
					free_head_q <= link_nx;
				end
			end
			if (cmd.free_done) begin
				free_head_q  <= LW'(head_ext);
				free_count_q <= fc_add;
			end
		end
	end

	// result of the transaction in progress
	always_comb begin
		res_nx = res_q;
		if (cmd.do_get) begin
			res_nx = '0;
			if (get_ok) begin
				res_nx.status         = npca_pkg::ST_DONE;
				res_nx.node_index     = (free_head_q < NIL) ? 9'(free_head_q) : 9'd0;
				res_nx.free_remaining = 10'(fc_sub);
			end else begin
				res_nx.status         = npca_pkg::ST_REFUSED;
				res_nx.free_remaining = 10'(free_count_q);
			end
		end else if (cmd.res_plain || cmd.res_stray) begin
			res_nx                = '0;
			res_nx.status         = cmd.res_stray ? npca_pkg::ST_STRAY : npca_pkg::ST_DONE;
			res_nx.free_remaining = 10'(free_count_q);
		end else if (cmd.do_short) begin
			res_nx                = '0;
			res_nx.chain_done     = 1'b1;
			res_nx.free_remaining = 10'(free_count_q);
		end else if (cmd.commit) begin
			res_nx.status         = npca_pkg::ST_DONE;
			res_nx.node_index     = 9'(cursor_q);
			res_nx.parent_index   = par_ok ? 9'(walk_q) : 9'd0;
			res_nx.parent_valid   = par_ok;
			res_nx.chain_done     = pending_q == LW'(1);
			res_nx.free_remaining = 10'(free_count_q);
		end else if (cmd.free_done) begin
			res_nx                = '0;
			res_nx.free_remaining = 10'(fc_add);
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			item_q <= in_item;
		end
		if (cmd.pwalk_start) begin
			walk_q  <= (item_q.parent_offset == npca_pkg::NO_PARENT) ? NIL
				: ((chain_top_q < NIL) ? chain_top_q : NIL);
			steps_q <= item_q.parent_offset;
		end else if (cmd.pwalk_step) begin
			walk_q  <= link_nx;
			steps_q <= steps_q - 8'd1;
		end else if (cmd.fwalk_start) begin
			walk_q <= LW'(head_ext);
			cnt_q  <= LW'(1);
		end else if (cmd.fwalk_step) begin
			walk_q <= link_nx;
			cnt_q  <= cnt_q + LW'(1);
		end
		res_q <= res_nx;
		if (cmd.out_ld) begin
			out_q <= res_q;
		end
	end

	assign out_item = out_q;

endmodule

FILE: rtl/core/npca_ctrl.sv
// Controller: sequences init sweep, walks and result hand-off.
module npca_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  npca_pkg::dp_sts_t  sts,
	output npca_pkg::ctl_cmd_t cmd
);
	npca_pkg::state_t state_q;
	npca_pkg::state_t state_nx;
	logic             out_valid_q;
	logic             out_room;

	assign out_room  = !out_valid_q || out_ready;
	assign in_ready  = state_q == npca_pkg::S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			npca_pkg::S_INIT: begin
				if (sts.init_last) state_nx = npca_pkg::S_IDLE;
			end
			npca_pkg::S_IDLE: begin
				if (in_valid) state_nx = npca_pkg::S_EXEC;
			end
			npca_pkg::S_EXEC: begin
				priority if (sts.op == npca_pkg::OP_HIER && !sts.pending_zero
					&& !sts.cursor_nil) begin
					state_nx = npca_pkg::S_PWALK;
				end else if (sts.op == npca_pkg::OP_FREE && sts.free_ok) begin
					state_nx = npca_pkg::S_FWALK;
				end else begin
					state_nx = npca_pkg::S_EMIT;
				end
			end
			npca_pkg::S_PWALK: begin
				if (sts.walk_nil || sts.steps_zero) state_nx = npca_pkg::S_NEXT_RD;
				else state_nx = npca_pkg::S_PWALK_WT;
			end
			npca_pkg::S_PWALK_WT: state_nx = npca_pkg::S_PWALK;
			npca_pkg::S_NEXT_RD:  state_nx = npca_pkg::S_NEXT_WT;
			npca_pkg::S_NEXT_WT:  state_nx = npca_pkg::S_EMIT;
			npca_pkg::S_FWALK: begin
				if (sts.cnt_full) state_nx = npca_pkg::S_FDONE;
				else state_nx = npca_pkg::S_FWALK_WT;
			end
			npca_pkg::S_FWALK_WT: begin
				if (sts.link_nil) state_nx = npca_pkg::S_FDONE;
				else state_nx = npca_pkg::S_FWALK;
			end
			npca_pkg::S_FDONE: state_nx = npca_pkg::S_EMIT;
			npca_pkg::S_EMIT: begin
				if (out_room) state_nx = npca_pkg::S_IDLE;
			end
			default: state_nx = npca_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			npca_pkg::S_INIT: cmd.init_wr = 1'b1;
			npca_pkg::S_IDLE: cmd.ld_item = in_valid;
			npca_pkg::S_EXEC: begin
				unique case (sts.op)
					npca_pkg::OP_GET: cmd.do_get = 1'b1;
					npca_pkg::OP_HIER: begin
						priority if (sts.pending_zero) cmd.res_stray = 1'b1;
						else if (sts.cursor_nil) cmd.do_short = 1'b1;
						else cmd.pwalk_start = 1'b1;
					end
					npca_pkg::OP_FREE: begin
						if (sts.free_ok) cmd.fwalk_start = 1'b1;
						else cmd.res_plain = 1'b1;
					end
					default: cmd.res_plain = 1'b1;
				endcase
			end
			npca_pkg::S_PWALK: begin
				cmd.walk_rd = !(sts.walk_nil || sts.steps_zero);
			end
			npca_pkg::S_PWALK_WT: cmd.pwalk_step = 1'b1;
			npca_pkg::S_NEXT_RD:  cmd.next_rd = 1'b1;
			npca_pkg::S_NEXT_WT:  cmd.commit = 1'b1;
			npca_pkg::S_FWALK:    cmd.walk_rd = !sts.cnt_full;
			npca_pkg::S_FWALK_WT: cmd.fwalk_step = !sts.link_nil;
			npca_pkg::S_FDONE:    cmd.free_done = 1'b1;
			npca_pkg::S_EMIT:     cmd.out_ld = out_room;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= npca_pkg::S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_ld) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/node_pool_chain_allocator.sv
// Top level of the node pool chain allocator: controller, datapath, checks.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid / in_ready     | in_item  (npca_pkg::in_item_t)
//  out     | output    | out_valid / out_ready   | out_item (npca_pkg::out_item_t)
//
// After reset a sweep over all POOL_SIZE entries chains the link memory; in_ready is low.
// One transaction at a time. A hierarchy item walks at most 254 links to its parent.
// A free walks the returned chain to its end, stopping after POOL_SIZE nodes.
// Each walk step is one read of the link memory followed by a check state.
// A held result waits in the output register; the next transaction is taken
// meanwhile and only its hand-off stalls on out_ready.
`include "assert_macros.svh"

module node_pool_chain_allocator #(
	parameter int POOL_SIZE = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  npca_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output npca_pkg::out_item_t out_item
);
	npca_pkg::ctl_cmd_t cmd;
	npca_pkg::dp_sts_t  sts;

	npca_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	npca_datapath #(
		.POOL_SIZE (POOL_SIZE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

	// one transaction in flight: an accept always drops ready next cycle
	`NPCA_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// at most one link memory write source per cycle
	`NPCA_ASSERT(a_one_writer, $onehot0({cmd.init_wr, cmd.commit, cmd.free_done}))
	// chain completion only ever reported with a done status
	`NPCA_ASSERT(a_done_status,
		!(out_valid && out_item.chain_done) || out_item.status == npca_pkg::ST_DONE)
	// refused or stray results carry no node and no parent
	`NPCA_ASSERT(a_refused_empty,
		!(out_valid && out_item.status != npca_pkg::ST_DONE)
		|| (!out_item.parent_valid && out_item.node_index == 9'd0))

endmodule

FILE: bench/node_pool_chain_allocator_test.sv
// Testbench for the node pool chain allocator: queue-fed driver, predictor, result checker.
module node_pool_chain_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL = 512;
	localparam int NIL = POOL;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	npca_pkg::in_item_t in_item;
	logic out_valid;
	logic out_ready;
	npca_pkg::out_item_t out_item;

	node_pool_chain_allocator #(.POOL_SIZE(POOL)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	// Predictor copy of the pool. A link value of NIL means null.
	int unsigned nxt[POOL];
	int unsigned par_of[POOL];
	int unsigned fr_head, fr_count, owed, top_node, cur_node, prev_node;

	npca_pkg::in_item_t pending_items[$];
	npca_pkg::out_item_t expected_results[$];

	int errors = 0;
	int checked = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_sender = 0;
	int unsigned cycles = 0;

	// Clock: 2 ns period.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int unsigned step_link(int unsigned node);
		if (node >= NIL)
			return NIL;
		return (nxt[node] < NIL) ? nxt[node] : NIL;
	endfunction

	function automatic void pool_reset();
		for (int i = 0; i < POOL; i++) begin
			nxt[i] = i + 1;
			par_of[i] = NIL;
		end
		fr_head = 0;
		fr_count = POOL;
		owed = 0;
		top_node = 0;
		cur_node = 0;
		prev_node = NIL;
	endfunction

	// Computes the result of one transaction and advances the pool state.
	function automatic npca_pkg::out_item_t allocate_step(npca_pkg::in_item_t it);
		npca_pkg::out_item_t r;
		int unsigned nd, pr, cnt, p, old;
		r = '0;
		if (it.opcode == npca_pkg::OP_GET) begin
			if (it.node_count == 0 || it.node_count > fr_count || owed != 0) begin
				r.status = npca_pkg::ST_REFUSED;
			end else begin
				fr_count -= it.node_count;
				top_node = fr_head;
				cur_node = fr_head;
				prev_node = NIL;
				owed = it.node_count;
				r.status = npca_pkg::ST_DONE;
				r.node_index = (top_node < NIL) ? top_node[8:0] : 9'd0;
			end
		end else if (it.opcode == npca_pkg::OP_HIER) begin
			if (owed == 0) begin
				r.status = npca_pkg::ST_STRAY;
			end else if (cur_node >= NIL) begin
				// short list: chain ends early
				owed = 0;
				fr_head = NIL;
				r.chain_done = 1'b1;
			end else begin
				nd = cur_node;
				if (it.parent_offset == npca_pkg::NO_PARENT) begin
					pr = NIL;
				end else begin
					pr = (top_node < NIL) ? top_node : NIL;
					for (int j = it.parent_offset; j > 0 && pr < NIL; j--)
						pr = step_link(pr);
				end
				par_of[nd] = pr;
				prev_node = nd;
				cur_node = step_link(nd);
				owed--;
				r.node_index = nd[8:0];
				r.parent_valid = (pr < NIL);
				r.parent_index = (pr < NIL) ? pr[8:0] : 9'd0;
				if (owed == 0) begin
					fr_head = cur_node;
					nxt[nd] = NIL;
					r.chain_done = 1'b1;
				end
			end
		end else if (it.opcode == npca_pkg::OP_FREE && it.chain_present
				&& it.chain_head < NIL && owed == 0) begin
			old = fr_head;
			p = it.chain_head;
			cnt = 1;
			fr_head = it.chain_head;
			while (cnt < POOL && step_link(p) < NIL) begin
				p = step_link(p);
				cnt++;
			end
			nxt[p] = old;
			fr_count = (fr_count + cnt > POOL) ? POOL : fr_count + cnt;
		end
		r.free_remaining = fr_count[9:0];
		return r;
	endfunction

	function automatic npca_pkg::in_item_t make_item(logic [1:0] op, int n, int off, int head,
			bit pres);
		npca_pkg::in_item_t it;
		it.opcode = op;
		it.node_count = n[9:0];
		it.parent_offset = off[7:0];
		it.chain_head = head[8:0];
		it.chain_present = pres;
		return it;
	endfunction

	// Random field noise on every bit but the opcode.
	function automatic npca_pkg::in_item_t rand_item(logic [1:0] op);
		npca_pkg::in_item_t it;
		logic [31:0] rnd;
		rnd = $urandom;
		it = rnd[$bits(npca_pkg::in_item_t)-1:0];
		it.opcode = op;
		return it;
	endfunction

	// Driver: valid stays up with a stable payload until accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(allocate_step(in_item));
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && !hold_sender
						&& $urandom_range(99, 0) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_item <= pending_items.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		npca_pkg::out_item_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			cycles++;
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_item);
					errors++;
				end else begin
					e = expected_results.pop_front();
					checked++;
					if (e.status != out_item.status || e.node_index != out_item.node_index
							|| e.parent_index != out_item.parent_index
							|| e.parent_valid != out_item.parent_valid
							|| e.chain_done != out_item.chain_done
							|| e.free_remaining != out_item.free_remaining) begin
						$display("%0t: mismatch expected %p actual %p", $time, e, out_item);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// One allocation: a get of n nodes followed by its hierarchy items.
	task automatic queue_chain(int n);
		npca_pkg::in_item_t it;
		it = rand_item(npca_pkg::OP_GET);
		it.node_count = 10'(n);
		pending_items.push_back(it);
		for (int k = 0; k < n; k++) begin
			it = rand_item(npca_pkg::OP_HIER);
			case ($urandom_range(3, 0))
				0: it.parent_offset = npca_pkg::NO_PARENT;
				1: it.parent_offset = 8'($urandom_range(255, 0));
				default: it.parent_offset = 8'($urandom_range(n, 0));
			endcase
			pending_items.push_back(it);
		end
	endtask

	initial begin
		int phase_items;
		int n_chain;
		npca_pkg::in_item_t it;
		arst_n = 1'b0;
		pool_reset();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: refusals, stray item, extremes, no-op, frees.
		pending_items.push_back(make_item(npca_pkg::OP_HIER, 0, 0, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_GET, 0, 0, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_GET, 1023, 255, 511, 1));
		pending_items.push_back(make_item(OP_UNUSED, 1023, 255, 511, 1));
		pending_items.push_back(make_item(npca_pkg::OP_FREE, 0, 0, 5, 0));
		pending_items.push_back(make_item(npca_pkg::OP_GET, 3, 0, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_GET, 1, 0, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_FREE, 0, 0, 0, 1));
		pending_items.push_back(make_item(npca_pkg::OP_HIER, 0, 0, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_HIER, 0, 2, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_HIER, 0, 255, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_HIER, 0, 0, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_GET, 509, 0, 0, 0));
		pending_items.push_back(make_item(npca_pkg::OP_FREE, 0, 0, 0, 1));
		pending_items.push_back(make_item(npca_pkg::OP_GET, 512, 0, 0, 0));

		// Sender stops after the queue empties and waits for every result.
		while (pending_items.size() != 0)
			@(posedge clk);
		hold_sender = 1;
		queue_chain(3);
		while (in_valid || expected_results.size() != 0)
			@(posedge clk);
		hold_sender = 0;
		drain();

		// Random phases with varying idle patterns.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 49; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 49; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			phase_items = 0;
			while (phase_items < 110) begin
				case ($urandom_range(9, 0))
					0, 1, 2, 3, 4: begin
						// well-formed allocation, mostly small
						if ($urandom_range(15, 0) == 0)
							n_chain = $urandom_range(60, 1);
						else
							n_chain = $urandom_range(6, 1);
						queue_chain(n_chain);
						phase_items += n_chain;
					end
					5, 6: begin
						it = rand_item(npca_pkg::OP_FREE);
						it.chain_present = $urandom_range(5, 0) != 0;
						pending_items.push_back(it);
					end
					7: pending_items.push_back(rand_item(npca_pkg::OP_GET));
					8: pending_items.push_back(rand_item(npca_pkg::OP_HIER));
					default: pending_items.push_back(rand_item(2'($urandom_range(3, 0))));
				endcase
				phase_items++;
			end
			drain();
		end

		repeat (200) @(posedge clk);
		$display("Checked %0d results over directed refusals, chain gets, frees and", checked);
		$display("random traffic under sender idling and receiver stalls.");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
